>>> rtl/assert_macros.svh
// Assertion macros for the frame parser RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcfp_pkg.sv
// Types and constants for the tagged configuration frame parser.
// No dependencies; imported by every module of the block.
package tcfp_pkg;

    localparam int CALL_MAX    = 16;
    localparam int SHORT_MAX   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TAG_CALL  = 8'h00;
    localparam logic [7:0] TAG_SHORT = 8'h01;
    localparam logic [7:0] TAG_LAT   = 8'h02;
    localparam logic [7:0] TAG_LON   = 8'h03;
    localparam logic [7:0] TAG_ALT   = 8'h04;

    // field flag bit positions
    localparam int FL_CALL  = 0;
    localparam int FL_SHORT = 1;
    localparam int FL_LAT   = 2;
    localparam int FL_LON   = 3;
    localparam int FL_ALT   = 4;

    typedef enum logic [1:0] {
        KIND_CALL    = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [12:0] {
        PH_FIRST     = 13'b0_0000_0000_0001,
        PH_CALL_LEN  = 13'b0_0000_0000_0010,
        PH_CALL      = 13'b0_0000_0000_0100,
        PH_SHORT_LEN = 13'b0_0000_0000_1000,
        PH_SHORT     = 13'b0_0000_0001_0000,
        PH_LAT       = 13'b0_0000_0010_0000,
        PH_LON       = 13'b0_0000_0100_0000,
        PH_ALT       = 13'b0_0000_1000_0000,
        PH_TAG1      = 13'b0_0001_0000_0000,
        PH_TAG2      = 13'b0_0010_0000_0000,
        PH_TAG3      = 13'b0_0100_0000_0000,
        PH_TAG4      = 13'b0_1000_0000_0000,
        PH_IDLE      = 13'b1_0000_0000_0000
    } phase_t;

    // one classified input byte: up to one character and one summary
    typedef struct packed {
        logic               has_char;
        kind_t              char_kind;
        logic [7:0]         char_value;
        logic               has_sum;
        logic               frame_ok;
        logic [4:0]         flags;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] alt;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/tagged_config_frame_parser_top.sv
// Tagged configuration frame parser, top level.
// Depends on tcfp_pkg, tcfp_front, tcfp_queue, tcfp_back and assert_macros.svh.
//
// Input channel: one frame byte per beat (byte_value, is_last, empty_frame),
// taken when in_valid is high and in_stall low. in_stall rises only when the
// four-entry op queue is full.
// Output channel: one result per beat, taken when out_valid is high and
// out_stall low. The first 16 bytes of a callsign or short name give
// character beats; the last byte of a frame (or an empty frame) gives a
// summary beat with end_of_frame set, after which the parser is back at the frame start.
// A result passes through the op queue and then the output register before
// it shows on out_valid; a summary behind a character follows as its own beat.
// Throughput: one input beat per cycle while in_stall is low; an input beat
// that carries both a character and the summary needs two output beats, so the
// output register sets the sustained rate when frames end on a name byte.
// While out_stall is held the output register keeps its beat, the queue
// fills, and after four queued ops the input is stalled too.
// Reset (rst_n low, asynchronous) empties queue and output register and
// returns the parser to the frame start with all gathered values cleared.
`include "assert_macros.svh"

module tagged_config_frame_parser_top
    import tcfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               is_last,
    input  logic               empty_frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [7:0]         char_value,
    output logic               frame_ok,
    output logic               has_call,
    output logic               has_short,
    output logic               has_lat,
    output logic               has_lon,
    output logic               has_alt,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic signed [31:0] altitude,
    output logic               end_of_frame
);

    logic    push;
    logic    pop;
    op_t     push_op;
    op_t     head_op;
    q_stat_t q_stat;
    logic    char_beat;
    logic    summary_beat;
    logic    char_fields_clear;

    tcfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_value  (byte_value),
        .is_last     (is_last),
        .empty_frame (empty_frame),
        .q_stat      (q_stat),
        .push        (push),
        .push_op     (push_op)
    );

    tcfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    tcfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_op      (head_op),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .char_value   (char_value),
        .frame_ok     (frame_ok),
        .has_call     (has_call),
        .has_short    (has_short),
        .has_lat      (has_lat),
        .has_lon      (has_lon),
        .has_alt      (has_alt),
        .latitude     (latitude),
        .longitude    (longitude),
        .altitude     (altitude),
        .end_of_frame (end_of_frame)
    );

    assign char_beat         = out_valid && result_kind != KIND_SUMMARY;
    assign summary_beat      = out_valid && result_kind == KIND_SUMMARY;
    assign char_fields_clear = !frame_ok && !has_call && !has_short && !has_lat && !has_lon
        && !has_alt && latitude == 0 && longitude == 0 && altitude == 0 && !end_of_frame;

    `TCFP_ASSERT_IMP(a_char_beat_clean, char_beat, char_fields_clear, "character beat carries summary data")
    `TCFP_ASSERT_IMP(a_eof_on_summary, out_valid, end_of_frame == summary_beat, "end_of_frame mismatch")
    `TCFP_ASSERT_IMP(a_ok_needs_call, summary_beat && frame_ok, has_call, "frame ok without callsign")
    `TCFP_ASSERT_IMP(a_queue_status, q_stat.full, !q_stat.empty, "queue both full and empty")

endmodule

>>> rtl/tcfp_front.sv
// Front end: accepts input beats, runs the frame parse and pushes result ops.
// Depends on tcfp_pkg.
module tcfp_front
    import tcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic       is_last,
    input  logic       empty_frame,
    input  q_stat_t    q_stat,
    output logic       push,
    output op_t        push_op
);

    phase_t             phase_reg,   phase_next;
    logic [7:0]         left_reg,    left_next;
    logic [7:0]         copied_reg,  copied_next;
    logic [31:0]        shift_reg,   shift_next;
    logic [1:0]         idx_reg,     idx_next;
    logic signed [31:0] lat_reg,     lat_next;
    logic signed [31:0] lon_reg,     lon_next;
    logic signed [31:0] alt_reg,     alt_next;
    logic [4:0]         flags_reg,   flags_next;
    logic               failed_reg,  failed_next;

    logic  accept;
    op_t   op;

    // next phase after a byte at a tag position; min_tag is the lowest tag allowed
    function automatic phase_t tag_phase(input logic [7:0] b, input logic [2:0] min_tag);
        phase_t p;
        p = PH_IDLE;
        if (b == TAG_SHORT && min_tag <= 3'd1)
            p = PH_SHORT_LEN;
        else if (b == TAG_LAT && min_tag <= 3'd2)
            p = PH_LAT;
        else if (b == TAG_LON && min_tag <= 3'd3)
            p = PH_LON;
        else if (b == TAG_ALT && min_tag <= 3'd4)
            p = PH_ALT;
        return p;
    endfunction

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    always_comb
    begin
        logic [7:0]  left_dec;
        logic [31:0] word;
        logic        end_fail;

        phase_next  = phase_reg;
        left_next   = left_reg;
        copied_next = copied_reg;
        shift_next  = shift_reg;
        idx_next    = idx_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        alt_next    = alt_reg;
        flags_next  = flags_reg;
        failed_next = failed_reg;
        op          = '0;
        op.char_kind  = KIND_CALL;
        op.char_value = byte_value;
        left_dec    = left_reg - 8'd1;
        word        = {byte_value, shift_reg[23:0]};
        end_fail    = 1'b0;

        if (empty_frame)
        begin
            phase_next  = PH_FIRST;
            left_next   = '0;
            copied_next = '0;
            shift_next  = '0;
            idx_next    = '0;
            lat_next    = '0;
            lon_next    = '0;
            alt_next    = '0;
            flags_next  = '0;
            failed_next = 1'b1;
        end
        else if (!failed_reg)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (byte_value != TAG_CALL)
                        failed_next = 1'b1;
                    else
                        phase_next = PH_CALL_LEN;
                end
                PH_CALL_LEN:
                begin
                    if (byte_value == 8'd0)
                        failed_next = 1'b1;
                    else
                    begin
                        left_next   = byte_value;
                        copied_next = '0;
                        phase_next  = PH_CALL;
                    end
                end
                PH_CALL:
                begin
                    if (copied_reg < 8'(CALL_MAX))
                    begin
                        op.has_char = 1'b1;
                        copied_next = copied_reg + 8'd1;
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        flags_next[FL_CALL] = 1'b1;
                        phase_next = PH_TAG1;
                    end
                end
                PH_SHORT_LEN:
                begin
                    copied_next = '0;
                    left_next   = byte_value;
                    phase_next  = (byte_value == 8'd0) ? PH_TAG2 : PH_SHORT;
                end
                PH_SHORT:
                begin
                    if (copied_reg < 8'(SHORT_MAX))
                    begin
                        op.has_char  = 1'b1;
                        op.char_kind = KIND_SHORT;
                        copied_next  = copied_reg + 8'd1;
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        flags_next[FL_SHORT] = 1'b1;
                        phase_next = PH_TAG2;
                    end
                end
                PH_LAT, PH_LON, PH_ALT:
                begin
                    // little-endian: each byte lands in its own lane
                    if (idx_reg == 2'd3)
                    begin
                        idx_next = '0;
                        if (phase_reg == PH_LAT)
                        begin
                            lat_next = word;
                            flags_next[FL_LAT] = 1'b1;
                            phase_next = PH_TAG3;
                        end
                        else if (phase_reg == PH_LON)
                        begin
                            lon_next = word;
                            flags_next[FL_LON] = 1'b1;
                            phase_next = PH_TAG4;
                        end
                        else
                        begin
                            alt_next = word;
                            flags_next[FL_ALT] = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        shift_next[8*idx_reg +: 8] = byte_value;
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_TAG1, PH_TAG2, PH_TAG3, PH_TAG4:
                begin
                    case (phase_reg)
                        PH_TAG1: phase_next = tag_phase(byte_value, 3'd1);
                        PH_TAG2: phase_next = tag_phase(byte_value, 3'd2);
                        PH_TAG3: phase_next = tag_phase(byte_value, 3'd3);
                        default: phase_next = tag_phase(byte_value, 3'd4);
                    endcase
                    if (phase_next != PH_IDLE)
                        idx_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (is_last || empty_frame)
        begin
            // ending before any tag position means something was cut short
            end_fail = failed_next || (phase_next inside {PH_FIRST, PH_CALL_LEN, PH_CALL,
                PH_SHORT_LEN, PH_SHORT, PH_LAT, PH_LON, PH_ALT});
            op.has_sum  = 1'b1;
            op.frame_ok = !end_fail;
            op.flags    = flags_next;
            op.lat      = lat_next;
            op.lon      = lon_next;
            op.alt      = alt_next;

            phase_next  = PH_FIRST;
            left_next   = '0;
            copied_next = '0;
            shift_next  = '0;
            idx_next    = '0;
            lat_next    = '0;
            lon_next    = '0;
            alt_next    = '0;
            flags_next  = '0;
            failed_next = 1'b0;
        end
    end

    assign push    = accept && (op.has_char || op.has_sum);
    assign push_op = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            left_reg   <= '0;
            copied_reg <= '0;
            shift_reg  <= '0;
            idx_reg    <= '0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            alt_reg    <= '0;
            flags_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            copied_reg <= copied_next;
            shift_reg  <= shift_next;
            idx_reg    <= idx_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            alt_reg    <= alt_next;
            flags_reg  <= flags_next;
            failed_reg <= failed_next;
        end
    end

endmodule

>>> rtl/tcfp_queue.sv
// Small op queue between parser front end and output back end.
// Depends on tcfp_pkg.
module tcfp_queue
    import tcfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_op,
    input  logic    pop,
    output op_t     head_op,
    output q_stat_t q_stat
);

    op_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_op      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/tcfp_back.sv
// Back end: splits queued ops into result beats held in an output register.
// Depends on tcfp_pkg.
module tcfp_back
    import tcfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                head_op,
    input  q_stat_t            q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [7:0]         char_value,
    output logic               frame_ok,
    output logic               has_call,
    output logic               has_short,
    output logic               has_lat,
    output logic               has_lon,
    output logic               has_alt,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic signed [31:0] altitude,
    output logic               end_of_frame
);

    logic               valid_reg,     valid_next;
    logic               char_done_reg, char_done_next;
    kind_t              kind_reg,      kind_next;
    logic [7:0]         char_reg,      char_next;
    logic               ok_reg,        ok_next;
    logic [4:0]         flags_reg,     flags_next;
    logic signed [31:0] lat_reg,       lat_next;
    logic signed [31:0] lon_reg,       lon_next;
    logic signed [31:0] alt_reg,       alt_next;

    logic load;
    logic take;
    logic emit_char;

    assign load      = !valid_reg || !out_stall;
    assign take      = load && !q_stat.empty;
    assign emit_char = head_op.has_char && !char_done_reg;
    // an op with a character and a summary stays at the head until its summary beat is taken
    assign pop       = take && !(emit_char && head_op.has_sum);

    always_comb
    begin
        valid_next     = valid_reg;
        char_done_next = char_done_reg;
        kind_next      = kind_reg;
        char_next      = char_reg;
        ok_next        = ok_reg;
        flags_next     = flags_reg;
        lat_next       = lat_reg;
        lon_next       = lon_reg;
        alt_next       = alt_reg;

        if (load)
            valid_next = 1'b0;
        if (take)
        begin
            valid_next     = 1'b1;
            char_done_next = emit_char && head_op.has_sum;
            if (emit_char)
            begin
                kind_next  = head_op.char_kind;
                char_next  = head_op.char_value;
                ok_next    = 1'b0;
                flags_next = '0;
                lat_next   = '0;
                lon_next   = '0;
                alt_next   = '0;
            end
            else
            begin
                kind_next  = KIND_SUMMARY;
                char_next  = '0;
                ok_next    = head_op.frame_ok;
                flags_next = head_op.flags;
                lat_next   = head_op.lat;
                lon_next   = head_op.lon;
                alt_next   = head_op.alt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            char_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            char_done_reg <= char_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        char_reg  <= char_next;
        ok_reg    <= ok_next;
        flags_reg <= flags_next;
        lat_reg   <= lat_next;
        lon_reg   <= lon_next;
        alt_reg   <= alt_next;
    end

    assign out_valid    = valid_reg;
    assign result_kind  = kind_reg;
    assign char_value   = char_reg;
    assign frame_ok     = ok_reg;
    assign has_call     = flags_reg[FL_CALL];
    assign has_short    = flags_reg[FL_SHORT];
    assign has_lat      = flags_reg[FL_LAT];
    assign has_lon      = flags_reg[FL_LON];
    assign has_alt      = flags_reg[FL_ALT];
    assign latitude     = lat_reg;
    assign longitude    = lon_reg;
    assign altitude     = alt_reg;
    assign end_of_frame = (kind_reg == KIND_SUMMARY);

endmodule
